// ===== rtl/core/crs_pkg.sv =====
package crs_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // parameter value one in Q1.16
  localparam logic [T_W-1:0] T_ONE = 17'd65536;

  // reset value of point_count
  localparam logic [CNT_W-1:0] COUNT_RST = 7'd4;

  // register index carried in paddr[2]
  localparam logic REG_POINT_COUNT = 1'b0;

  // item mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // decoupling queue depth
  localparam int QUEUE_DEPTH = 4;

  // number of register stages in the evaluation pipeline
  localparam int BACK_STAGES = 7;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // one evaluation in flight: four neighboring points and the parameter
  typedef struct packed {
    point_t [3:0]     pts;
    logic [T_W-1:0]   t;
  } crs_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic avail;
  } crs_qstat_t;

endpackage

// ===== rtl/core/crs_front.sv =====
module crs_front import crs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int BD = (MAX_POINTS + 3) / 4,
  localparam int RW = (BD > 1) ? $clog2(BD) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic [IDX_W-1:0]          in_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [T_W-1:0]            in_t_param,
  input  logic [AW-1:0]             seg_last,
  input  crs_qstat_t                qstat,
  output logic                      q_push,
  output crs_item_t                 q_item
);

  logic            in_fire;
  logic            is_eval;
  logic            seg_lo;
  logic            seg_hi;
  logic [AW-1:0]   base_c;
  logic [T_W-1:0]  t_c;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  point_t          wr_pt;
  logic            rd_en;
  point_t          bank_q [4];

  logic            f_valid_r, f_valid_nxt;
  logic [1:0]      f_rot_r;
  logic [T_W-1:0]  f_t_r;

  assign in_stall = f_valid_r && qstat.full;
  assign in_fire  = in_valid && !in_stall;
  assign q_push   = f_valid_r && !qstat.full;

  // classify the item and pick the first of the four points
  always_comb begin
    is_eval = (in_mode == MODE_EVAL);
    seg_lo  = (in_index == '0);
    seg_hi  = (32'(in_index) >= 32'(seg_last));
    if (seg_lo) begin
      base_c = '0;
    end else if (seg_hi) begin
      base_c = seg_last - AW'(2);
    end else begin
      base_c = AW'(32'(in_index) - 32'd1);
    end
    // first segment runs the curve at t zero, end segments at t one,
    // so every point read stays inside the table
    if (seg_lo) begin
      t_c = '0;
    end else if (seg_hi || in_t_param > T_ONE) begin
      t_c = T_ONE;
    end else begin
      t_c = in_t_param;
    end
  end

  // point writes go to bank index[1:0], row index[5:2]
  assign wr_en  = in_fire && !is_eval && (32'(in_index) < 32'(MAX_POINTS));
  assign wr_row = RW'(in_index >> 2);
  assign wr_pt  = '{z: in_coord_z, y: in_coord_y, x: in_coord_x};
  assign rd_en  = in_fire && is_eval;

  // four banks: any four consecutive points hit each bank once
  for (genvar b = 0; b < 4; b++) begin : g_bank
    point_t         bank_mem_r [BD];
    point_t         rd_q_r;
    logic [1:0]     k;
    logic [AW:0]    j;
    logic [RW-1:0]  rd_row;

    assign k      = 2'(b) - base_c[1:0];
    assign j      = (AW+1)'(base_c) + (AW+1)'(k);
    assign rd_row = RW'(j >> 2);

    always_ff @(posedge clk) begin
      if (wr_en && in_index[1:0] == 2'(b)) begin
        bank_mem_r[wr_row] <= wr_pt;
      end
      if (rd_en) begin
        rd_q_r <= bank_mem_r[rd_row];
      end
    end

    assign bank_q[b] = rd_q_r;
  end

  // read stage control
  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_fire) begin
      f_valid_nxt = is_eval;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      f_rot_r <= base_c[1:0];
      f_t_r   <= t_c;
    end
  end

  // undo the bank rotation so point k is base+k
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_item.pts[k] = bank_q[2'(f_rot_r + 2'(k))];
    end
    q_item.t = f_t_r;
  end

endmodule

// ===== rtl/core/crs_queue.sv =====
module crs_queue import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  crs_item_t  push_item,
  input  logic       pop,
  output crs_qstat_t qstat,
  output crs_item_t  head
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  crs_item_t        q_mem_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (cnt_r == (QAW+1)'(QUEUE_DEPTH));
  assign qstat.avail = (cnt_r != '0);
  assign head        = q_mem_r[rd_ptr_r];

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && qstat.avail;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (QAW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (QAW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/crs_axis.sv =====
module crs_axis import crs_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] p0,
  input  logic signed [COORD_W-1:0] p1,
  input  logic signed [COORD_W-1:0] p2,
  input  logic signed [COORD_W-1:0] p3,
  input  logic [T_W-1:0]            t,
  output logic signed [COORD_W-1:0] pos
);

  // coefficient, Horner and product widths
  localparam int S_W = COORD_W + 1;
  localparam int A_W = COORD_W + 4;
  localparam int H_W = COORD_W + 6;
  localparam int M_W = H_W + T_W + 1;

  // product of a Horner value and t
  function automatic logic signed [M_W-1:0] mul_t(input logic signed [H_W-1:0] h,
                                                  input logic [T_W-1:0] tv);
    logic signed [T_W:0] ts;
    ts = $signed({1'b0, tv});
    return M_W'(h) * M_W'(ts);
  endfunction

  // drop 16 fraction bits, round half up
  function automatic logic signed [H_W-1:0] rnd16(input logic signed [M_W-1:0] m);
    logic signed [M_W-1:0] s;
    s = m + M_W'(32768);
    return H_W'(s >>> 16);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [H_W-1:0] v);
    logic [H_W-COORD_W:0] top;
    top = v[H_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[H_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic signed [A_W-1:0] x0, x1, x2, x3;
  logic signed [A_W-1:0] a2_c, a3_c;
  logic signed [H_W-1:0] h0_c, q_c;

  // stage 0: polynomial coefficients
  logic signed [S_W-1:0] s0_a0_r, s0_a1_r;
  logic signed [A_W-1:0] s0_a2_r, s0_a3_r;
  logic [T_W-1:0]        s0_t_r;
  // stage 1: a3 * t
  logic signed [M_W-1:0] s1_m_r;
  logic signed [S_W-1:0] s1_a0_r, s1_a1_r;
  logic signed [A_W-1:0] s1_a2_r;
  logic [T_W-1:0]        s1_t_r;
  // stage 2: add a2
  logic signed [H_W-1:0] s2_h_r;
  logic signed [S_W-1:0] s2_a0_r, s2_a1_r;
  logic [T_W-1:0]        s2_t_r;
  // stage 3: times t
  logic signed [M_W-1:0] s3_m_r;
  logic signed [S_W-1:0] s3_a0_r, s3_a1_r;
  logic [T_W-1:0]        s3_t_r;
  // stage 4: add a1
  logic signed [H_W-1:0] s4_h_r;
  logic signed [S_W-1:0] s4_a0_r;
  logic [T_W-1:0]        s4_t_r;
  // stage 5: times t
  logic signed [M_W-1:0] s5_m_r;
  logic signed [S_W-1:0] s5_a0_r;
  // stage 6: output register
  logic signed [COORD_W-1:0] pos_r;

  // coefficients from the four points
  always_comb begin
    x0   = A_W'(p0);
    x1   = A_W'(p1);
    x2   = A_W'(p2);
    x3   = A_W'(p3);
    a2_c = (x0 <<< 1) - ((x1 <<< 2) + x1) + (x2 <<< 2) - x3;
    a3_c = x1 + (x1 <<< 1) - x2 - (x2 <<< 1) + x3 - x0;
  end

  // last Horner step, halve and saturate
  always_comb begin
    h0_c = H_W'(s5_a0_r) + rnd16(s5_m_r);
    q_c  = (h0_c + H_W'(1)) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a0_r <= S_W'(p1) <<< 1;
      s0_a1_r <= S_W'(p2) - S_W'(p0);
      s0_a2_r <= a2_c;
      s0_a3_r <= a3_c;
      s0_t_r  <= t;

      s1_m_r  <= mul_t(H_W'(s0_a3_r), s0_t_r);
      s1_a0_r <= s0_a0_r;
      s1_a1_r <= s0_a1_r;
      s1_a2_r <= s0_a2_r;
      s1_t_r  <= s0_t_r;

      s2_h_r  <= H_W'(s1_a2_r) + rnd16(s1_m_r);
      s2_a0_r <= s1_a0_r;
      s2_a1_r <= s1_a1_r;
      s2_t_r  <= s1_t_r;

      s3_m_r  <= mul_t(s2_h_r, s2_t_r);
      s3_a0_r <= s2_a0_r;
      s3_a1_r <= s2_a1_r;
      s3_t_r  <= s2_t_r;

      s4_h_r  <= H_W'(s3_a1_r) + rnd16(s3_m_r);
      s4_a0_r <= s3_a0_r;
      s4_t_r  <= s3_t_r;

      s5_m_r  <= mul_t(s4_h_r, s4_t_r);
      s5_a0_r <= s4_a0_r;

      pos_r   <= sat32(q_c);
    end
  end

  assign pos = pos_r;

endmodule

// ===== rtl/core/crs_back.sv =====
module crs_back import crs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  crs_qstat_t                qstat,
  input  crs_item_t                 head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z
);

  logic                   en;
  logic [BACK_STAGES-1:0] vld_r, vld_nxt;

  // whole pipeline holds while a finished result waits
  assign en        = !(vld_r[BACK_STAGES-1] && out_stall);
  assign q_pop     = en && qstat.avail;
  assign out_valid = vld_r[BACK_STAGES-1];

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[BACK_STAGES-2:0], qstat.avail};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // one Horner pipeline per axis
  crs_axis u_axis_x (
    .clk (clk),
    .en  (en),
    .p0  (head.pts[0].x),
    .p1  (head.pts[1].x),
    .p2  (head.pts[2].x),
    .p3  (head.pts[3].x),
    .t   (head.t),
    .pos (out_pos_x)
  );

  crs_axis u_axis_y (
    .clk (clk),
    .en  (en),
    .p0  (head.pts[0].y),
    .p1  (head.pts[1].y),
    .p2  (head.pts[2].y),
    .p3  (head.pts[3].y),
    .t   (head.t),
    .pos (out_pos_y)
  );

  crs_axis u_axis_z (
    .clk (clk),
    .en  (en),
    .p0  (head.pts[0].z),
    .p1  (head.pts[1].z),
    .p2  (head.pts[2].z),
    .p3  (head.pts[3].z),
    .t   (head.t),
    .pos (out_pos_z)
  );

endmodule

// ===== rtl/core/catmull_rom_spline_eval.sv =====
// path: an evaluate transaction is read from the banks at its accepting edge, then waits in
// one queue slot and passes seven Horner stages (multiply and add alternate) before out_valid
// throughput: one transaction per cycle while in_stall is low; four point banks give four reads per cycle
// write transactions update the point table and return nothing
// reset clears the pipeline and queue and sets point_count to 4; points are
// undefined until written
module catmull_rom_spline_eval import crs_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic [IDX_W-1:0]          in_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [T_W-1:0]            in_t_param,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int AW = $clog2(MAX_POINTS);

  logic             cfg_wr;
  logic [CNT_W-1:0] wr_count;
  logic [CNT_W-1:0] point_count_r, point_count_nxt;
  logic [AW-1:0]    seg_last_r, seg_last_nxt;

  crs_qstat_t       qstat;
  crs_item_t        q_item;
  crs_item_t        q_head;
  logic             q_push;
  logic             q_pop;

  // configuration register
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wr_count = pwdata[CNT_W-1:0];
  assign prdata   = (paddr[2] == REG_POINT_COUNT) ? PDATA_W'(point_count_r) : '0;

  // keep the last usable segment start alongside the count
  always_comb begin
    point_count_nxt = point_count_r;
    seg_last_nxt    = seg_last_r;
    if (cfg_wr && paddr[2] == REG_POINT_COUNT) begin
      point_count_nxt = wr_count;
      if (32'(wr_count) > 32'(MAX_POINTS)) begin
        seg_last_nxt = AW'(MAX_POINTS - 2);
      end else if (wr_count < COUNT_RST) begin
        seg_last_nxt = AW'(2);
      end else begin
        seg_last_nxt = AW'(32'(wr_count) - 32'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= COUNT_RST;
      seg_last_r    <= AW'(2);
    end else begin
      point_count_r <= point_count_nxt;
      seg_last_r    <= seg_last_nxt;
    end
  end

  // accept, classify and read points
  crs_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_index   (in_index),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .in_t_param (in_t_param),
    .seg_last   (seg_last_r),
    .qstat      (qstat),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // decoupling queue
  crs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .qstat     (qstat),
    .head      (q_head)
  );

  // curve evaluation
  crs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z)
  );

endmodule

// ===== sim/catmull_rom_spline_eval_test.sv =====
module catmull_rom_spline_eval_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crs_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 175;
  localparam int REG_SPARE    = 1;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct {
    logic                      mode;
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [T_W-1:0]            t;
  } spline_req_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // point table copy, point count and the positions still owed by the block
  class curve_tracker;
    logic signed [COORD_W-1:0] slot_x [NUM_SLOTS];
    logic signed [COORD_W-1:0] slot_y [NUM_SLOTS];
    logic signed [COORD_W-1:0] slot_z [NUM_SLOTS];
    logic [CNT_W-1:0]          count_reg;
    point_t                    due_positions [$];
    int                        fail_count;

    function new();
      count_reg  = COUNT_RST;
      fail_count = 0;
      foreach (slot_x[i]) begin
        slot_x[i] = '0;
        slot_y[i] = '0;
        slot_z[i] = '0;
      end
    endfunction

    function void write_reg(int reg_idx, logic [PDATA_W-1:0] value);
      if (reg_idx == int'(REG_POINT_COUNT)) begin
        count_reg = value[CNT_W-1:0];
      end
    endfunction

    // count is clamped to between four and the table size before the end segment is found
    function int last_segment();
      int span;
      span = int'(count_reg);
      if (span < 4) span = 4;
      if (span > NUM_SLOTS) span = NUM_SLOTS;
      return span - 2;
    endfunction

    // horner form with round half up per step, then halved and saturated
    static function logic signed [COORD_W-1:0] axis_position(longint p0, longint p1,
                                                             longint p2, longint p3,
                                                             longint tq);
      longint c0, c1, c2, c3, h;
      c0 = 2 * p1;
      c1 = p2 - p0;
      c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c3 = -p0 + 3 * p1 - 3 * p2 + p3;
      h = c3;
      h = c2 + ((h * tq + 32768) >>> 16);
      h = c1 + ((h * tq + 32768) >>> 16);
      h = c0 + ((h * tq + 32768) >>> 16);
      h = (h + 1) >>> 1;
      if (h > POS_MAX) h = POS_MAX;
      if (h < POS_MIN) h = POS_MIN;
      return h[COORD_W-1:0];
    endfunction

    function void note_item(spline_req_t req);
      point_t pos;
      int     seg;
      int     last;
      int     pick;
      longint tq;
      if (req.mode == MODE_WRITE) begin
        slot_x[req.index] = req.x;
        slot_y[req.index] = req.y;
        slot_z[req.index] = req.z;
        return;
      end
      last = last_segment();
      seg  = int'(req.index);
      if (seg == 0 || seg >= last) begin
        // first segment gives point one, end segments give the last inner point
        pick  = (seg == 0) ? 1 : last;
        pos.x = slot_x[pick];
        pos.y = slot_y[pick];
        pos.z = slot_z[pick];
      end else begin
        tq = (req.t > T_ONE) ? longint'(T_ONE) : longint'(req.t);
        pos.x = axis_position(slot_x[seg-1], slot_x[seg], slot_x[seg+1], slot_x[seg+2], tq);
        pos.y = axis_position(slot_y[seg-1], slot_y[seg], slot_y[seg+1], slot_y[seg+2], tq);
        pos.z = axis_position(slot_z[seg-1], slot_z[seg], slot_z[seg+1], slot_z[seg+2], tq);
      end
      due_positions.push_back(pos);
    endfunction

    function void compare_axis(string axis, logic signed [COORD_W-1:0] want,
                               logic signed [COORD_W-1:0] got);
      if (want !== got) begin
        fail_count++;
        $display("%0t: pos_%s expected %0d got %0d", $time, axis, want, got);
      end
    endfunction

    function void check_position(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z);
      point_t want;
      if (due_positions.size() == 0) begin
        fail_count++;
        $display("%0t: position expected none got %0d %0d %0d", $time, x, y, z);
        return;
      end
      want = due_positions.pop_front();
      compare_axis("x", want.x, x);
      compare_axis("y", want.y, y);
      compare_axis("z", want.z, z);
    endfunction

    function int pending();
      return due_positions.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_mode;
  logic [IDX_W-1:0]          in_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic [T_W-1:0]            in_t_param;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_pos_x;
  logic signed [COORD_W-1:0] out_pos_y;
  logic signed [COORD_W-1:0] out_pos_z;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  curve_tracker     board = new();
  logic             bursty;
  int               burst_left = 0;
  logic [31:0]      stall_cycle = '0;
  logic [PDATA_W-1:0] count_settings [8];

  catmull_rom_spline_eval DUT (.*);

  always #5 clk = ~clk;

  // receiver stall pattern cycles through four styles
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_mode_t'(stall_cycle[9:8]))
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
      default:     out_stall <= (stall_cycle % 5 < 2);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_position(out_pos_x, out_pos_y, out_pos_z);
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return COORD_MIN;
        1:       return COORD_MAX;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end
    if (r < 45) return $urandom;
    return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
  endfunction

  function automatic logic [T_W-1:0] random_t();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return T_ONE;
    if (r < 30) return T_W'($urandom_range(65537, 131071));
    return T_W'($urandom_range(0, 65535));
  endfunction

  // mostly evaluations inside the curve, some at both ends and some point writes
  function automatic spline_req_t random_request();
    spline_req_t req;
    int unsigned r;
    int          last;
    last      = board.last_segment();
    req.x     = random_coord();
    req.y     = random_coord();
    req.z     = random_coord();
    req.t     = random_t();
    req.index = IDX_W'($urandom_range(0, 63));
    if ($urandom_range(0, 9) < 3) begin
      req.mode = MODE_WRITE;
    end else begin
      req.mode = MODE_EVAL;
      r = $urandom_range(0, 99);
      if (r < 8) req.index = '0;
      else if (r < 16) req.index = IDX_W'($urandom_range(last, 63));
      else if (r < 22) req.index = IDX_W'(last - 1);
      else req.index = IDX_W'($urandom_range(1, last - 1));
    end
    return req;
  endfunction

  // drive one transaction, hold it until accepted, then maybe open a gap
  task automatic send_request(input spline_req_t req);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_mode    <= req.mode;
    in_index   <= req.index;
    in_coord_x <= req.x;
    in_coord_y <= req.y;
    in_coord_z <= req.z;
    in_t_param <= req.t;
    do @(posedge clk); while (in_stall);
    board.note_item(req);
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_point(input int slot, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    spline_req_t req;
    req = '{mode: MODE_WRITE, index: IDX_W'(slot), x: x, y: y, z: z, t: random_t()};
    send_request(req);
  endtask

  task automatic eval_at(input int seg, input logic [T_W-1:0] tq);
    spline_req_t req;
    req = '{mode: MODE_EVAL, index: IDX_W'(seg), x: random_coord(), y: random_coord(),
            z: random_coord(), t: tq};
    send_request(req);
  endtask

  // drop valid and let every owed position come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write followed by a readback of the point count
  task automatic cfg_write(input int reg_idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] got;
    logic [PDATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(reg_idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(reg_idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    paddr   <= PADDR_W'(int'(REG_POINT_COUNT) * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got  = prdata;
    want = PDATA_W'(board.count_reg);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      board.fail_count++;
      $display("%0t: point_count readback expected %0d got %0d", $time, want, got);
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    in_mode    = MODE_WRITE;
    in_index   = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_t_param = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_n      = 1'b0;
    bursty     = 1'b1;
    count_settings = '{32'd64, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd65, 32'd17, 32'd40, 32'd4};
    count_settings[6] = $urandom_range(5, 63);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole table so no evaluation reads an unwritten slot
    for (int s = 0; s < NUM_SLOTS; s++) begin
      write_point(s, random_coord(), random_coord(), random_coord());
    end

    // extreme points around segment one push the curve past the signed 32-bit range
    write_point(0, COORD_MIN, COORD_MAX, 0);
    write_point(1, COORD_MAX, COORD_MIN, 1);
    write_point(2, COORD_MAX, COORD_MIN, -1);
    write_point(3, COORD_MIN, COORD_MAX, 0);
    eval_at(1, 0);
    eval_at(1, T_ONE);
    eval_at(1, 32768);
    eval_at(1, 17'h1FFFF);
    eval_at(1, 1);
    eval_at(1, 16384);
    eval_at(0, 500);
    eval_at(2, 1000);
    eval_at(63, 0);
    write_point(63, COORD_MAX, COORD_MIN, COORD_MAX);
    eval_at(63, 49152);
    eval_at(1, 49152);

    // random phases, one point count setting each
    foreach (count_settings[i]) begin
      wait_idle();
      if (i == 2) cfg_write(REG_SPARE, $urandom);
      cfg_write(int'(REG_POINT_COUNT), count_settings[i]);
      bursty = (i % 3 != 1);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    wait_idle();

    if (board.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
